### rtl/hpw_pkg.sv
// package for the hit pair window straight pid block
// types, register indexes, modes and sizes used by the block's modules
package hpw_pkg;

  localparam int EW = 17;
  localparam int PW = 13;
  localparam int CW = 18;
  localparam int HITS_MAX = 8;
  localparam int SLOT_W = 3;
  localparam int CNT_W = 4;

  // register indexes
  localparam logic [2:0] REG_WIN_MIN = 3'd0;
  localparam logic [2:0] REG_WIN_MAX = 3'd1;
  localparam logic [2:0] REG_WIN_EN  = 3'd2;
  localparam logic [2:0] REG_COEF_A  = 3'd3;
  localparam logic [2:0] REG_COEF_B  = 3'd4;

  // input modes
  localparam logic [1:0] MODE_LEFT   = 2'd0;
  localparam logic [1:0] MODE_RIGHT  = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_FETCH,
    ST_CHECK,
    ST_CALC,
    ST_OUT,
    ST_EMPTY
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic store_left;
    logic store_right;
    logic set_drop;
    logic clear_event;
    logic fetch;
    logic calc_start;
    logic capture;
    logic load_out;
    logic load_empty;
    logic out_last;
    logic [SLOT_W-1:0] li;
    logic [SLOT_W-1:0] ri;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] left_count;
    logic [CNT_W-1:0] right_count;
    logic             in_window;
    logic             calc_done;
    logic             out_busy;
  } stat_t;

endpackage

### rtl/hpw_sqrt.sv
// iterative square root and straightening arithmetic, one root bit per cycle
// depends on hpw_pkg
module hpw_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [hpw_pkg::EW-1:0]    e,
  input  logic [hpw_pkg::EW-1:0]    de,
  input  logic [hpw_pkg::CW-1:0]    coef_a,
  input  logic signed [hpw_pkg::CW-1:0] coef_b,
  output logic                      done,
  output logic [hpw_pkg::EW-1:0]    ef,
  output logic                      sat
);

  typedef enum logic [2:0] {
    P_IDLE, P_M1, P_M2, P_ROOT, P_FIN
  } phase_t;

  phase_t phase;
  logic [33:0] p_dee;
  logic [33:0] p_dd;
  logic [53:0] rad;
  logic [53:0] rem_v;
  logic [27:0] root;
  logic [4:0]  step;
  logic signed [35:0] be;

  // one restoring step: one root bit per cycle
  logic [55:0] trial;
  logic [55:0] rem_sh;
  always_comb begin
    rem_sh = {rem_v, rad[53:52]};
    trial  = {root, 2'b01};
  end

  logic signed [37:0] t;
  always_comb begin
    t = $signed({2'b00, root, 8'd0}) + 38'(be);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: if (start) begin
          p_dee <= 34'(de) * 34'(e);
          p_dd  <= 34'(de) * 34'(de);
          phase <= P_M1;
        end
        P_M1: begin
          rad   <= {4'd0, p_dee, 16'd0} + 54'(52'(p_dd) * 52'(coef_a));
          be    <= 36'(coef_b) * $signed({1'b0, e});
          phase <= P_M2;
        end
        P_M2: begin
          rem_v <= '0;
          root  <= '0;
          step  <= 5'd0;
          phase <= P_ROOT;
        end
        P_ROOT: begin
          if (rem_sh >= trial) begin
            rem_v <= 54'(rem_sh - trial);
            root  <= {root[26:0], 1'b1};
          end else begin
            rem_v <= rem_sh[53:0];
            root  <= {root[26:0], 1'b0};
          end
          rad  <= {rad[51:0], 2'b00};
          step <= step + 5'd1;
          if (step == 5'd26) phase <= P_FIN;
        end
        P_FIN: begin
          if (t < 0) begin
            ef  <= '0;
            sat <= 1'b1;
          end else if (t[37:16] > 22'd131071) begin
            ef  <= '1;
            sat <= 1'b1;
          end else begin
            ef  <= t[32:16];
            sat <= 1'b0;
          end
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

### rtl/hpw_datapath.sv
// hit storage, window compare, held pair result, output register
// depends on hpw_pkg and hpw_sqrt
module hpw_datapath #(
  parameter int MAX_HITS = hpw_pkg::HITS_MAX
) (
  input  logic clk,
  input  logic rst,
  input  hpw_pkg::cmd_t cmd,
  output hpw_pkg::stat_t stat,
  input  logic [hpw_pkg::EW-1:0] hit_energy,
  input  logic signed [hpw_pkg::PW-1:0] hit_x,
  input  logic signed [hpw_pkg::PW-1:0] hit_y,
  input  logic signed [hpw_pkg::PW-1:0] window_min,
  input  logic signed [hpw_pkg::PW-1:0] window_max,
  input  logic window_enable,
  input  logic [hpw_pkg::CW-1:0] coef_a,
  input  logic signed [hpw_pkg::CW-1:0] coef_b,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [63:0] m_tdata,
  output logic m_tlast
);

  localparam int HW = hpw_pkg::EW + 2 * hpw_pkg::PW;

  logic [HW-1:0] left_mem [MAX_HITS];
  logic [HW-1:0] right_mem [MAX_HITS];
  logic [hpw_pkg::CNT_W-1:0] left_count, right_count;
  logic dropped;
  logic [HW-1:0] lh, rh;
  logic [hpw_pkg::SLOT_W-1:0] li_q, ri_q;
  logic [58:0] held;

  // hit stores and counts
  always_ff @(posedge clk) begin
    if (cmd.store_left) left_mem[left_count[hpw_pkg::SLOT_W-1:0]] <= {hit_energy, hit_x, hit_y};
    if (cmd.store_right) right_mem[right_count[hpw_pkg::SLOT_W-1:0]] <= {hit_energy, hit_x, hit_y};
    if (cmd.fetch) begin
      lh   <= left_mem[cmd.li];
      rh   <= right_mem[cmd.ri];
      li_q <= cmd.li;
      ri_q <= cmd.ri;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
      dropped     <= 1'b0;
    end else if (cmd.clear_event) begin
      left_count  <= '0;
      right_count <= '0;
      dropped     <= 1'b0;
    end else begin
      if (cmd.store_left) left_count <= left_count + 1'b1;
      if (cmd.store_right) right_count <= right_count + 1'b1;
      if (cmd.set_drop) dropped <= 1'b1;
    end
  end

  // window compare on fetched pair
  logic signed [hpw_pkg::PW:0] dx, dy;
  always_comb begin
    dx = $signed({rh[2*hpw_pkg::PW-1], rh[2*hpw_pkg::PW-1:hpw_pkg::PW]})
       - $signed({lh[2*hpw_pkg::PW-1], lh[2*hpw_pkg::PW-1:hpw_pkg::PW]});
    dy = $signed({rh[hpw_pkg::PW-1], rh[hpw_pkg::PW-1:0]})
       - $signed({lh[hpw_pkg::PW-1], lh[hpw_pkg::PW-1:0]});
  end

  logic win_ok;
  assign win_ok = !window_enable ||
    (dx >= window_min && dx <= window_max && dy >= window_min && dy <= window_max);

  logic calc_done, sat;
  logic [hpw_pkg::EW-1:0] ef;

  hpw_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(cmd.calc_start),
    .e(rh[HW-1 -: hpw_pkg::EW]), .de(lh[HW-1 -: hpw_pkg::EW]),
    .coef_a(coef_a), .coef_b(coef_b),
    .done(calc_done), .ef(ef), .sat(sat)
  );

  // counting pair held until the walk knows whether it is the last one
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      held <= {sat, ri_q, li_q, ef, lh[HW-1 -: hpw_pkg::EW], rh[HW-1 -: hpw_pkg::EW], 1'b1};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cmd.load_out || cmd.load_empty) m_tvalid <= 1'b1;
    end
    if (cmd.load_out) begin
      m_tdata <= {4'd0, dropped, held};
      m_tlast <= cmd.out_last;
    end else if (cmd.load_empty) begin
      m_tdata <= {4'd0, dropped, 59'd0};
      m_tlast <= 1'b1;
    end
  end

  assign stat.left_count  = left_count;
  assign stat.right_count = right_count;
  assign stat.in_window   = win_ok;
  assign stat.calc_done   = calc_done;
  assign stat.out_busy    = m_tvalid && !m_tready;

endmodule

### rtl/hpw_ctrl.sv
// controller: hit collection and pair walk sequencer
// depends on hpw_pkg
module hpw_ctrl #(
  parameter int MAX_HITS = hpw_pkg::HITS_MAX
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [1:0] mode,
  input  hpw_pkg::stat_t stat,
  output hpw_pkg::cmd_t cmd
);

  hpw_pkg::state_t state, state_next;
  logic [hpw_pkg::CNT_W-1:0] li, ri, li_next, ri_next;
  logic any, any_next;
  logic pend, pend_next;
  logic acc, wrap_r, more;

  assign acc = s_tvalid && s_tready;
  assign wrap_r = (ri + 1'b1) >= stat.right_count;
  assign more = !(wrap_r && (li + 1'b1) >= stat.left_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpw_pkg::ST_COLLECT;
      li <= '0; ri <= '0; any <= 1'b0; pend <= 1'b0;
    end else begin
      state <= state_next;
      li <= li_next; ri <= ri_next; any <= any_next; pend <= pend_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    li_next = li; ri_next = ri; any_next = any; pend_next = pend;
    case (state)
      hpw_pkg::ST_COLLECT: if (acc && mode == hpw_pkg::MODE_END) begin
        li_next = '0; ri_next = '0; any_next = 1'b0;
        if (stat.left_count == '0 || stat.right_count == '0)
          state_next = hpw_pkg::ST_EMPTY;
        else
          state_next = hpw_pkg::ST_FETCH;
      end
      hpw_pkg::ST_FETCH: state_next = hpw_pkg::ST_CHECK;
      hpw_pkg::ST_CHECK: begin
        if (stat.in_window) begin
          state_next = hpw_pkg::ST_CALC;
        end else if (more) begin
          state_next = hpw_pkg::ST_FETCH;
          if (wrap_r) begin li_next = li + 1'b1; ri_next = '0; end
          else ri_next = ri + 1'b1;
        end else if (any) begin
          state_next = hpw_pkg::ST_OUT;
          pend_next = 1'b1;
        end else begin
          state_next = hpw_pkg::ST_EMPTY;
        end
      end
      hpw_pkg::ST_CALC: if (stat.calc_done) begin
        state_next = hpw_pkg::ST_OUT;
        pend_next = 1'b0;
      end
      hpw_pkg::ST_OUT: if (!stat.out_busy) begin
        // pend set: walk is over, the held pair goes out as the last one
        any_next = 1'b1;
        if (pend) begin
          pend_next = 1'b0;
          state_next = hpw_pkg::ST_COLLECT;
        end else if (more) begin
          state_next = hpw_pkg::ST_FETCH;
          if (wrap_r) begin li_next = li + 1'b1; ri_next = '0; end
          else ri_next = ri + 1'b1;
        end else pend_next = 1'b1;
      end
      hpw_pkg::ST_EMPTY: if (!stat.out_busy) state_next = hpw_pkg::ST_COLLECT;
      default: state_next = hpw_pkg::ST_COLLECT;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.li = li[hpw_pkg::SLOT_W-1:0];
    cmd.ri = ri[hpw_pkg::SLOT_W-1:0];
    s_tready = 1'b0;
    case (state)
      hpw_pkg::ST_COLLECT: begin
        s_tready = 1'b1;
        if (acc && mode == hpw_pkg::MODE_LEFT) begin
          if (stat.left_count < hpw_pkg::CNT_W'(MAX_HITS)) cmd.store_left = 1'b1;
          else cmd.set_drop = 1'b1;
        end
        if (acc && mode == hpw_pkg::MODE_RIGHT) begin
          if (stat.right_count < hpw_pkg::CNT_W'(MAX_HITS)) cmd.store_right = 1'b1;
          else cmd.set_drop = 1'b1;
        end
      end
      hpw_pkg::ST_FETCH: cmd.fetch = 1'b1;
      hpw_pkg::ST_CHECK: cmd.calc_start = stat.in_window;
      hpw_pkg::ST_OUT: if (!stat.out_busy) begin
        if (pend) begin
          cmd.load_out = 1'b1;
          cmd.out_last = 1'b1;
          cmd.clear_event = 1'b1;
        end else begin
          // send the previous pair, hold the new one
          cmd.capture = 1'b1;
          cmd.load_out = any;
        end
      end
      hpw_pkg::ST_EMPTY: if (!stat.out_busy) begin
        cmd.load_empty = 1'b1;
        cmd.clear_event = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### rtl/hit_pair_window_straight_pid.sv
// top level of the hit pair window straight pid block
// an end item walks every pair: a pair outside the window is only fetched and checked,
//   a counting pair also gets the multiplies and a 27 step square root;
//   each counting result is held until the next one is found, the last leaves after the walk
// throughput: one hit item per cycle; no item is taken during the pair walk
// reset: rst synchronous active high clears counts, flags, state, output valid and config registers to defaults
// depends on hpw_pkg, hpw_ctrl, hpw_datapath
module hit_pair_window_straight_pid #(
  parameter int MAX_HITS = hpw_pkg::HITS_MAX
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // mode[1:0], hit_energy[18:2], hit_x[31:19], hit_y[44:32]
  input  logic [47:0] s_tdata,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [17:0] cfg_data,
  output logic m_tvalid,
  input  logic m_tready,
  // pair_valid[0], e_value[17:1], de_value[34:18], straight_value[51:35],
  // left_slot[54:52], right_slot[57:55], saturated[58], hits_dropped[59]
  output logic [63:0] m_tdata,
  output logic m_tlast
);

  logic signed [hpw_pkg::PW-1:0] window_min, window_max;
  logic window_enable;
  logic [hpw_pkg::CW-1:0] coef_a;
  logic signed [hpw_pkg::CW-1:0] coef_b;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_min <= -13'sd64;
      window_max <= 13'sd64;
      window_enable <= 1'b1;
      coef_a <= 18'd32768;
      coef_b <= -18'sd2621;
    end else if (cfg_we) begin
      case (cfg_index)
        hpw_pkg::REG_WIN_MIN: window_min <= cfg_data[12:0];
        hpw_pkg::REG_WIN_MAX: window_max <= cfg_data[12:0];
        hpw_pkg::REG_WIN_EN:  window_enable <= cfg_data[0];
        hpw_pkg::REG_COEF_A:  coef_a <= cfg_data;
        hpw_pkg::REG_COEF_B:  coef_b <= cfg_data;
        default: ;
      endcase
    end
  end

  hpw_pkg::cmd_t cmd;
  hpw_pkg::stat_t stat;
  logic [2:0] unused_pad;
  assign unused_pad = s_tdata[47:45];

  hpw_ctrl #(.MAX_HITS(MAX_HITS)) u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .mode(s_tdata[1:0]), .stat(stat), .cmd(cmd)
  );

  hpw_datapath #(.MAX_HITS(MAX_HITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .hit_energy(s_tdata[18:2]), .hit_x(s_tdata[31:19]), .hit_y(s_tdata[44:32]),
    .window_min(window_min), .window_max(window_max), .window_enable(window_enable),
    .coef_a(coef_a), .coef_b(coef_b),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule
